/* rtl/core/swm_pkg.sv */
// Shared constants and types for the sliding window maximum block.
package swm_pkg;

    localparam int MAX_WINDOW = 256;
    localparam int SAMPLE_W   = 31;
    localparam int SIZE_W     = 9;
    localparam int PTR_W      = $clog2(MAX_WINDOW);
    localparam int FILL_W     = $clog2(MAX_WINDOW + 1);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(3);
    localparam logic [FILL_W-1:0] FILL_MAX   = FILL_W'(MAX_WINDOW);

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [FILL_W-1:0]   fill_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FINISH
    } swm_state_t;

endpackage

/* rtl/core/sliding_window_maximum.sv */
// Top level of the sliding window maximum block with its window memory and scan sequencer.
//
// Each accepted sample is written to a 256-entry window memory, and once the current
// sequence holds at least window_size samples the block scans the older window entries
// through the memory's single read port, one entry per cycle with registered read data,
// and presents the maximum on the result channel. An item that gives no result is only
// written to the memory. An item with a window of one goes straight from the accept to
// the output hand-off; a wider window first runs the one-read-per-cycle memory scan.
// The hand-off waits longer while an earlier beat still sits unaccepted in the output
// register. The next sample is accepted as soon as the result is in the output register,
// even while it waits for m_ready. The memory needs no clearing pass after reset.
module sliding_window_maximum (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [swm_pkg::SIZE_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [swm_pkg::SAMPLE_W-1:0]   s_sample,
    input  logic                           s_first_of_sequence,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [swm_pkg::SAMPLE_W-1:0]   m_window_max
);
    import swm_pkg::*;

    sample_t    mem [MAX_WINDOW];
    sample_t    rd_data_reg;
    logic       rd_pend_reg;

    swm_state_t state_reg, state_next;
    logic [SIZE_W-1:0] size_reg;
    fill_t      fill_reg, fill_next, fill_base;
    ptr_t       wp_reg;
    ptr_t       idx_reg, idx_next;
    ptr_t       last_reg;
    sample_t    max_reg, max_next;
    logic       out_vld_reg;
    sample_t    out_reg;

    logic       accept;
    logic       emit;
    fill_t      w_eff;
    logic       rd_en;
    ptr_t       rd_addr;
    logic       out_load;
    logic       out_free;

    always_comb begin
        if (size_reg == '0) begin
            w_eff = FILL_W'(1);
        end else if (FILL_W'(size_reg) > FILL_MAX) begin
            w_eff = FILL_MAX;
        end else begin
            w_eff = FILL_W'(size_reg);
        end
    end

    assign accept    = s_valid && s_ready;
    assign fill_base = s_first_of_sequence ? '0 : fill_reg;
    assign fill_next = (fill_base < FILL_MAX) ? fill_base + FILL_W'(1) : fill_base;
    assign emit      = fill_next >= w_eff;
    assign out_free  = !out_vld_reg || m_ready;
    assign rd_addr   = wp_reg - PTR_W'(1) - idx_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && emit) begin
                    state_next = (w_eff == FILL_W'(1)) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_reg == last_reg) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        rd_en    = 1'b0;
        out_load = 1'b0;
        idx_next = idx_reg;
        max_next = max_reg;
        if (rd_pend_reg && (rd_data_reg > max_reg)) begin
            max_next = rd_data_reg;
        end
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                idx_next = PTR_W'(1);
                if (accept) begin
                    max_next = s_sample;
                end
            end
            ST_SCAN: begin
                rd_en    = 1'b1;
                idx_next = idx_reg + PTR_W'(1);
            end
            ST_LAST: begin
            end
            ST_FINISH: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mem[wp_reg] <= s_sample;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            size_reg    <= SIZE_RESET;
            fill_reg    <= '0;
            wp_reg      <= '0;
            rd_pend_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_en;
            if (cfg_we) begin
                size_reg <= cfg_wdata;
            end
            if (accept) begin
                fill_reg <= fill_next;
                wp_reg   <= wp_reg + PTR_W'(1);
            end
            if (out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        max_reg <= max_next;
        if (accept) begin
            last_reg <= PTR_W'(w_eff - FILL_W'(1));
        end
        if (out_load) begin
            out_reg <= max_reg;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_window_max = out_reg;

    // A read is only in flight right after a scan cycle.
    a_rd_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> $past(state_reg == ST_SCAN))
        else $error("read data pending without a preceding scan cycle");

    // No new sample is taken while a scan read is still outstanding.
    a_no_accept_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !rd_pend_reg)
        else $error("input ready while a window read is pending");

    // Finishing with a free output always presents a result on the next cycle.
    a_finish_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) && out_free |=> m_valid)
        else $error("finished item did not reach the output register");

    // The fill count never passes the window memory depth.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("fill count above window depth");

endmodule
